### design/assert_macros.svh
// Assertion macros for the evaluator RTL, used by the pipeline control.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define BEZ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the standard clk_i / rst_ni pair of the module.
`define BEZ_ASSERT_STD(lbl, prop, msg) \
  `BEZ_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### design/bez_pkg.sv
// Shared constants and types for the Bezier point evaluator.
`timescale 1ns / 1ps
package bez_pkg;

  localparam int COORD_W   = 32;
  localparam int T_W       = 18;
  localparam int T_FRAC    = 16;
  localparam int TC_W      = T_FRAC + 1;          // clamped t, 0..1.0 inclusive
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = DIFF_W + TC_W + 1;
  localparam int TYPE_W    = 2;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int REG_SEL_W = $clog2(NUM_REGS);
  localparam int NUM_AXES  = 2;
  localparam int NSTG      = 7;

  localparam logic [TYPE_W-1:0] REQ_LINEAR = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_QUAD   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CUBIC  = 2'd2;

  // Register map: point k, axis a sits at index 2*k + a.
  localparam logic [CFG_IDX_W-1:0] REG_P0_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P0_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P1_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P1_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P2_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P2_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P3_X = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_P3_Y = 4'd7;

  // Pipeline stages
  localparam int ST_CLAMP  = 0;
  localparam int ST_L1_MUL = 1;
  localparam int ST_L1_ADD = 2;
  localparam int ST_L2_MUL = 3;
  localparam int ST_L2_ADD = 4;
  localparam int ST_L3_MUL = 5;
  localparam int ST_L3_ADD = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [TC_W-1:0] tclamp_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic            in_ready;
    logic            out_valid;
  } pipe_ctl_t;

endpackage

### design/bez_req_if.sv
// Request channel: curve order and parameter t.
`timescale 1ns / 1ps
interface bez_req_if;
  import bez_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic signed [T_W-1:0]    t_param;

  modport source (output valid, output req_type, output t_param, input ready);
  modport sink   (input valid, input req_type, input t_param, output ready);
endinterface

### design/bez_pt_if.sv
// Result channel: evaluated curve point.
`timescale 1ns / 1ps
interface bez_pt_if;
  import bez_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

### design/bez_lerp.sv
// Two-stage linear interpolation slice: multiply stage, then shift and add.
`timescale 1ns / 1ps
module bez_lerp (
  input  logic             clk_i,
  input  logic             en_mul_i,
  input  logic             en_add_i,
  input  bez_pkg::coord_t  a_i,
  input  bez_pkg::coord_t  b_i,
  input  bez_pkg::tclamp_t t_i,
  output bez_pkg::coord_t  res_o
);
  import bez_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] shifted, sum;
  coord_t                   a_q;
  coord_t                   res_d, res_q;

  always_comb begin
    diff   = {b_i[COORD_W-1], b_i} - {a_i[COORD_W-1], a_i};
    prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, t_i}));
  end

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  // Arithmetic shift floors; the sum stays between a and b.
  always_comb begin
    shifted = prod_q >>> T_FRAC;
    sum     = shifted + {{(PROD_W-COORD_W){a_q[COORD_W-1]}}, a_q};
    res_d   = sum[COORD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_add_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### design/bez_pipe_ctrl.sv
// Valid/ready control for the evaluator pipeline, per-stage bubble collapse.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bez_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output bez_pkg::pipe_ctl_t ctl_o
);
  import bez_pkg::*;

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] rdy;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    rdy[NSTG-1] = !valid_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign ctl_o.en        = rdy;
  assign ctl_o.in_ready  = rdy[0];
  assign ctl_o.out_valid = valid_q[NSTG-1];

  `BEZ_ASSERT_STD(a_accept_loads, in_valid_i && rdy[0] |=> valid_q[0], "accepted transaction lost at entry")
  `BEZ_ASSERT_STD(a_stall_holds, valid_q[NSTG-1] && !out_ready_i |=> valid_q[NSTG-1], "stalled result dropped")
  `BEZ_ASSERT_STD(a_block_only_full, !rdy[0] |-> (&valid_q), "input blocked with a bubble in the pipe")

endmodule

### design/bezier_curve_point_evaluator.sv
// Top level of the 2D de Casteljau Bezier point evaluator.
// Usage:
//   Control points p0..p3 (x, y, signed Q16.16) are written through the plain
//   config port (cfg_we_i, cfg_idx_i, cfg_data_i) while no transaction is in
//   flight. Index order is p0_x, p0_y, p1_x, ... p3_y; indexes above 7 are ignored.
//   Each request transaction carries req_type (0 linear, 1 quadratic, 2 or 3
//   cubic) and t_param (signed Q1.16). t is clamped to [0, 1.0] once at entry,
//   which gives the same result as clamping at every interpolation.
//   One point transaction (point_x, point_y) comes out per request, in order.
// Timing:
//   Seven register stages: one clamp stage, then a multiply stage and an add
//   stage for each of the three interpolation levels. The clamp stage loads at
//   the request accept edge; the result is valid from the last add stage.
//   A new request can be taken every cycle unless the full pipeline is stalled.
// Reset:
//   rst_ni clears all control points to zero and empties the pipeline.
// Backpressure:
//   While the result is stalled, empty stages still fill; req.ready drops
//   only once every stage holds a transaction.
`timescale 1ns / 1ps
module bezier_curve_point_evaluator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bez_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bez_pkg::COORD_W-1:0]    cfg_data_i,
  bez_req_if.sink                        req,
  bez_pt_if.source                       pt
);
  import bez_pkg::*;

  localparam logic signed [T_W-1:0] T_ONE = T_W'(1 << T_FRAC);

  pipe_ctl_t         ctl;
  coord_t            cfg_q [NUM_REGS];
  tclamp_t           t_q   [NSTG-2];
  logic [TYPE_W-1:0] ord_q [NSTG];
  tclamp_t           t_clamp;

  coord_t l1  [NUM_AXES][3];
  coord_t l2  [NUM_AXES][2];
  coord_t l3  [NUM_AXES];
  coord_t lin_dly_q  [NUM_AXES][4];   // stages 3..6
  coord_t quad_dly_q [NUM_AXES][2];   // stages 5..6
  coord_t point [NUM_AXES];

  bez_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .out_ready_i (pt.ready),
    .ctl_o       (ctl)
  );

  assign req.ready = ctl.in_ready;
  assign pt.valid  = ctl.out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= REG_P3_Y)) begin
      cfg_q[cfg_idx_i[REG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    if (req.t_param <= $signed(T_W'(0))) begin
      t_clamp = '0;
    end else if (req.t_param >= T_ONE) begin
      t_clamp = T_ONE[TC_W-1:0];
    end else begin
      t_clamp = req.t_param[TC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[ST_CLAMP]) begin
      t_q[ST_CLAMP]   <= t_clamp;
      ord_q[ST_CLAMP] <= req.req_type;
    end
  end

  for (genvar s = 1; s < NSTG; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (ctl.en[s]) begin
        ord_q[s] <= ord_q[s-1];
      end
    end
    if (s < NSTG - 2) begin : g_t
      always_ff @(posedge clk_i) begin
        if (ctl.en[s]) begin
          t_q[s] <= t_q[s-1];
        end
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    for (genvar k = 0; k < 3; k++) begin : g_l1
      bez_lerp u_lerp (
        .clk_i    (clk_i),
        .en_mul_i (ctl.en[ST_L1_MUL]),
        .en_add_i (ctl.en[ST_L1_ADD]),
        .a_i      (cfg_q[2*k + a]),
        .b_i      (cfg_q[2*k + 2 + a]),
        .t_i      (t_q[ST_CLAMP]),
        .res_o    (l1[a][k])
      );
    end
    for (genvar k = 0; k < 2; k++) begin : g_l2
      bez_lerp u_lerp (
        .clk_i    (clk_i),
        .en_mul_i (ctl.en[ST_L2_MUL]),
        .en_add_i (ctl.en[ST_L2_ADD]),
        .a_i      (l1[a][k]),
        .b_i      (l1[a][k+1]),
        .t_i      (t_q[ST_L1_ADD]),
        .res_o    (l2[a][k])
      );
    end
    bez_lerp u_l3 (
      .clk_i    (clk_i),
      .en_mul_i (ctl.en[ST_L3_MUL]),
      .en_add_i (ctl.en[ST_L3_ADD]),
      .a_i      (l2[a][0]),
      .b_i      (l2[a][1]),
      .t_i      (t_q[ST_L2_ADD]),
      .res_o    (l3[a])
    );

    // Carry the linear and quadratic answers alongside the deeper levels.
    always_ff @(posedge clk_i) begin
      if (ctl.en[ST_L2_MUL]) lin_dly_q[a][0] <= l1[a][0];
      if (ctl.en[ST_L2_ADD]) lin_dly_q[a][1] <= lin_dly_q[a][0];
      if (ctl.en[ST_L3_MUL]) begin
        lin_dly_q[a][2]  <= lin_dly_q[a][1];
        quad_dly_q[a][0] <= l2[a][0];
      end
      if (ctl.en[ST_L3_ADD]) begin
        lin_dly_q[a][3]  <= lin_dly_q[a][2];
        quad_dly_q[a][1] <= quad_dly_q[a][0];
      end
    end

    always_comb begin
      case (ord_q[ST_L3_ADD])
        REQ_LINEAR: point[a] = lin_dly_q[a][3];
        REQ_QUAD:   point[a] = quad_dly_q[a][1];
        REQ_CUBIC:  point[a] = l3[a];
        default:    point[a] = l3[a];
      endcase
    end
  end

  assign pt.point_x = point[0];
  assign pt.point_y = point[1];

endmodule

### tb/sv/tb_top.sv
// Testbench for the de Casteljau Bezier point evaluator: directed probes, then randomized checking.
`timescale 1ns / 1ps
module tb_top;
  import bez_pkg::*;

  localparam int     CLK_HALF       = 6;
  localparam int     RST_CYCLES     = 8;
  localparam int     PIPE_LAT       = 7;
  localparam int     N_PHASES       = 5;
  localparam int     PHASE_ITEMS    = 220;
  localparam int     SQUEEZE_CYCLES = 120;
  localparam int     MAX_REPORTS    = 10;
  localparam longint CYCLE_LIMIT    = 400000;
  localparam longint T_ONE          = longint'(1) << T_FRAC;

  // curve order 3 is not listed, the block treats it as cubic
  localparam logic [TYPE_W-1:0]    REQ_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_MAX = 32'sh7FFF_FFFF;

  // control points used by the directed probes
  localparam coord_t D0X = C_MIN;
  localparam coord_t D0Y = C_MAX;
  localparam coord_t D1X = C_MAX;
  localparam coord_t D1Y = C_MIN;
  localparam coord_t D2X = 32'sh0001_8000;
  localparam coord_t D2Y = C_MIN;
  localparam coord_t D3X = C_MAX;
  localparam coord_t D3Y = 32'shFFFF_0000;

  typedef struct packed {
    logic [TYPE_W-1:0]     kind;
    logic signed [T_W-1:0] t;
    bit                    known;
    coord_t                px;
    coord_t                py;
  } probe_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } point_t;

  // known = 1 rows carry the point read straight off the clamp rules
  localparam probe_t PROBES [20] = '{
    '{REQ_LINEAR, 18'sh20000, 1'b1, D0X, D0Y},
    '{REQ_QUAD,   18'sh3FFFF, 1'b1, D0X, D0Y},
    '{REQ_CUBIC,  18'sh00000, 1'b1, D0X, D0Y},
    '{REQ_SPARE,  18'sh30000, 1'b1, D0X, D0Y},
    '{REQ_LINEAR, 18'sh10000, 1'b1, D1X, D1Y},
    '{REQ_QUAD,   18'sh10000, 1'b1, D2X, D2Y},
    '{REQ_CUBIC,  18'sh1FFFF, 1'b1, D3X, D3Y},
    '{REQ_SPARE,  18'sh1FFFF, 1'b1, D3X, D3Y},
    '{REQ_QUAD,   18'sh11170, 1'b1, D2X, D2Y},
    '{REQ_LINEAR, 18'sh00001, 1'b0, '0, '0},
    '{REQ_QUAD,   18'sh00001, 1'b0, '0, '0},
    '{REQ_CUBIC,  18'sh00001, 1'b0, '0, '0},
    '{REQ_LINEAR, 18'sh08000, 1'b0, '0, '0},
    '{REQ_QUAD,   18'sh08000, 1'b0, '0, '0},
    '{REQ_CUBIC,  18'sh08000, 1'b0, '0, '0},
    '{REQ_SPARE,  18'sh08000, 1'b0, '0, '0},
    '{REQ_LINEAR, 18'sh0FFFF, 1'b0, '0, '0},
    '{REQ_QUAD,   18'sh0FFFF, 1'b0, '0, '0},
    '{REQ_CUBIC,  18'sh0FFFF, 1'b0, '0, '0},
    '{REQ_CUBIC,  18'sh05555, 1'b0, '0, '0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_W-1:0]   cfg_data_i;

  bez_req_if req_if ();
  bez_pt_if  pt_if ();

  bezier_curve_point_evaluator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .pt         (pt_if)
  );

  longint ctrl_pts [NUM_REGS];
  point_t pending_pts [$];
  point_t want;
  int     errors;
  longint cycle_cnt;
  bit     calm;
  bit     squeeze_req;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic longint blend(longint a, longint b, longint t);
    if (t <= 0) return a;
    if (t >= T_ONE) return b;
    // >>> on a signed longint floors, as the block's arithmetic shift does
    return a + (((b - a) * t) >>> T_FRAC);
  endfunction

  function automatic longint quad_pt(longint a, longint b, longint c, longint t);
    return blend(blend(a, b, t), blend(b, c, t), t);
  endfunction

  function automatic longint axis_point(logic [TYPE_W-1:0] kind, int ax, longint t);
    longint a, b, c, d;
    a = ctrl_pts[ax];
    b = ctrl_pts[2 + ax];
    c = ctrl_pts[4 + ax];
    d = ctrl_pts[6 + ax];
    case (kind)
      REQ_LINEAR: return blend(a, b, t);
      REQ_QUAD:   return quad_pt(a, b, c, t);
      default:    return blend(quad_pt(a, b, c, t), quad_pt(b, c, d, t), t);
    endcase
  endfunction

  function automatic point_t curve_point(logic [TYPE_W-1:0] kind, logic signed [T_W-1:0] t);
    point_t p;
    p.x = coord_t'(axis_point(kind, 0, longint'(t)));
    p.y = coord_t'(axis_point(kind, 1, longint'(t)));
    return p;
  endfunction

  // mostly short gaps, some medium, a few long; none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(0, 2))
          0:       return C_MIN;
          1:       return C_MAX;
          default: return '0;
        endcase
      end
      2: return coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return ($urandom_range(0, 1) != 0) ? C_MIN : coord_t'($urandom);
    endcase
  endfunction

  // call at a rising edge; returns at the next one with the write done
  task automatic load_ctrl(input logic [CFG_IDX_W-1:0] idx, input coord_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx < NUM_REGS) ctrl_pts[idx] = longint'(data);
  endtask

  task automatic send_req(input logic [TYPE_W-1:0] kind, input logic signed [T_W-1:0] t,
                          input bit known, input coord_t px, input coord_t py);
    int     gap;
    point_t p;
    gap = pick_gap();
    repeat (gap) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.t_param  <= t;
    do @(posedge clk_i); while (!req_if.ready);
    if (known) begin
      p.x = px;
      p.y = py;
    end else begin
      p = curve_point(kind, t);
    end
    pending_pts.push_back(p);
  endtask

  // wait for every expected point, then let the pipeline settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 3) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int                    n;
    int                    r;
    int                    mode;
    logic [TYPE_W-1:0]     kind;
    logic signed [T_W-1:0] t;
    errors      = 0;
    calm        = 1'b0;
    squeeze_req = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) ctrl_pts[i] = 0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_LINEAR;
    req_if.t_param  <= '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // control points are all zero out of reset
    send_req(REQ_CUBIC, 18'sh08000, 1'b1, '0, '0);
    send_req(REQ_LINEAR, 18'sh3FFFF, 1'b1, '0, '0);
    drain();

    load_ctrl(REG_P0_X, D0X);
    load_ctrl(REG_P0_Y, D0Y);
    load_ctrl(REG_P1_X, D1X);
    load_ctrl(REG_P1_Y, D1Y);
    load_ctrl(REG_P2_X, D2X);
    load_ctrl(REG_P2_Y, D2Y);
    load_ctrl(REG_P3_X, D3X);
    load_ctrl(REG_P3_Y, D3Y);
    // out-of-map indexes must not disturb the points
    load_ctrl(REG_UNUSED_LO, coord_t'($urandom));
    load_ctrl(REG_UNUSED_HI, coord_t'($urandom));
    cfg_we_i <= 1'b0;

    foreach (PROBES[i])
      send_req(PROBES[i].kind, PROBES[i].t, PROBES[i].known, PROBES[i].px, PROBES[i].py);
    drain();

    n = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      mode = ph % 4;
      for (int i = 0; i < NUM_REGS; i++)
        load_ctrl(i[CFG_IDX_W-1:0], pick_coord(mode));
      if (ph == 2) load_ctrl(REG_UNUSED_HI, coord_t'($urandom));
      cfg_we_i <= 1'b0;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        calm = ((n / 64) % 5 == 2);
        // back-to-back offers while the receiver is held off
        if (n == 128) squeeze_req = 1'b1;
        r = $urandom_range(0, 15);
        if (r == 15) begin
          kind = REQ_SPARE;
        end else begin
          case (r % 3)
            0:       kind = REQ_LINEAR;
            1:       kind = REQ_QUAD;
            default: kind = REQ_CUBIC;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          t = T_W'($urandom_range(0, 65536));
        end else if (r < 80) begin
          case ($urandom_range(0, 3))
            0:       t = 18'sh00000;
            1:       t = 18'sh00001;
            2:       t = 18'sh0FFFF;
            default: t = 18'sh10000;
          endcase
        end else begin
          t = T_W'($urandom);
        end
        send_req(kind, t, 1'b0, '0, '0);
        n++;
      end
      calm = 1'b0;
      drain();
    end

    repeat (PIPE_LAT * 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_sink
    int  stall;
    bit  squeezed;
    stall    = 0;
    squeezed = 1'b0;
    pt_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeezed) begin
        stall    = SQUEEZE_CYCLES;
        squeezed = 1'b1;
      end
      if (stall > 0) begin
        pt_if.ready <= 1'b0;
        stall--;
      end else begin
        pt_if.ready <= 1'b1;
        stall = pick_gap();
      end
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      if (pending_pts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected point transaction: x=%h y=%h", pt_if.point_x, pt_if.point_y);
      end else begin
        want = pending_pts.pop_front();
        if (pt_if.point_x !== want.x || pt_if.point_y !== want.y) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("point mismatch: expected x=%h y=%h, got x=%h y=%h",
                     want.x, want.y, pt_if.point_x, pt_if.point_y);
        end
      end
    end
  end

  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
